// ===== hdl/spfe_pkg.sv =====
package spfe_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned MAX_DEGREE_DEF = 7;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_VALUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_DEGREE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_DEGREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_KIND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_MODE     = 3'd4;

  localparam logic [1:0] CMD_LOAD_SPACE = 2'd0;
  localparam logic [1:0] CMD_LOAD_TIME  = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [2:0]               coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] comp_a;
    logic signed [DATA_W-1:0] comp_b;
    logic signed [DATA_W-1:0] comp_c;
    logic                     overflow;
  } out_item_t;

endpackage

// ===== hdl/separable_polynomial_field_evaluator.sv =====
// Load item: written into the coefficient memory at the edge where it is accepted.
// Evaluate item: time pass (effective degree Nt), x, y and (3D mode) z passes (effective Ns),
// then the final products; a new item is taken only after the result has been registered.
// Every Horner step and final product goes through one shared 32x32 multiplier,
// one step per cycle, with coefficients read from memories with registered read data.
// Async active-low reset clears config, control and the coefficient valid bits (tables read 0).
module separable_polynomial_field_evaluator import spfe_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_DEGREE + 1;
  localparam int unsigned IW     = $clog2(DEPTH);
  localparam int unsigned WIDE_W = 2 * DATA_W;
  localparam logic [IW-1:0] DEG_MAX = IW'(MAX_DEGREE);
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LD, ST_STEP_A, ST_STEP_B, ST_MUL, ST_FIN, ST_DONE
  } st_e;

  typedef enum logic [1:0] {PASS_T, PASS_X, PASS_Y, PASS_Z} pass_e;

  typedef enum logic [2:0] {
    OP_T_DX, OP_ACC_PY, OP_ACC_PZ_A, OP_T_PX, OP_ACC_DY, OP_ACC_PZ_B, OP_TP_PY, OP_ACC_DZ_C
  } op_e;

  typedef struct packed {
    logic                     ov;
    logic signed [DATA_W-1:0] v;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if ((x[WIDE_W-1:DATA_W-1] == '0) || (x[WIDE_W-1:DATA_W-1] == '1)) begin
      r.ov = 1'b0;
      r.v  = x[DATA_W-1:0];
    end else if (x[WIDE_W-1]) begin
      r.ov = 1'b1;
      r.v  = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r.ov = 1'b1;
      r.v  = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic signed [DATA_W-1:0] time_value_q;
  logic [2:0]               tdeg_q, sdeg_q;
  logic                     kind_q, dim2_q;

  // coefficient memories
  logic [DATA_W-1:0]        spat_mem [DEPTH];
  logic [DATA_W-1:0]        time_mem [DEPTH];
  logic [DEPTH-1:0]         spat_vld_q, time_vld_q;
  logic signed [DATA_W-1:0] srd_q, trd_q;
  logic                     srv_q, trv_q;

  // sequencer and datapath
  st_e                      st_q;
  pass_e                    pass_q;
  op_e                      op_q;
  logic [IW-1:0]            i_q;
  logic                     d_pend_q, ov_q, out_valid_q;
  logic signed [DATA_W-1:0] x_q, y_q, z_q;
  logic signed [DATA_W-1:0] r_p_q, r_d_q, coef_q, w_q;
  logic signed [WIDE_W-1:0] prod_q;
  logic signed [DATA_W-1:0] t_q, px_q, dx_q, py_q, dy_q, pz_q, dz_q;
  logic signed [DATA_W-1:0] acc_q, tp_q, res_a_q, res_b_q, res_c_q;
  out_item_t                out_item_q;

  logic                     in_acc, eval_acc, load_spat, load_time, idx_ok, out_free;
  logic [IW-1:0]            widx, nt, ns, n_cur, w_n, raddr;
  logic signed [DATA_W-1:0] s_cur, coef_rd, opa, opb, pzs, mul_a, mul_b, add_b;
  logic signed [DATA_W-1:0] end_rp, end_rd;
  logic signed [WIDE_W-1:0] mul_p, fl_x, add_x, w_x, neg_x;
  logic signed [IW:0]       w_ns;
  sat_t                     fl_s, add_s, w_s, neg_s;
  logic                     p_en, d_en, pass_end, last_op, ov_set;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign eval_acc    = in_acc && (in_item_i.cmd == CMD_EVAL);
  assign idx_ok      = (32'(in_item_i.coef_index) <= MAX_DEGREE);
  assign load_spat   = in_acc && (in_item_i.cmd == CMD_LOAD_SPACE) && idx_ok;
  assign load_time   = in_acc && (in_item_i.cmd == CMD_LOAD_TIME) && idx_ok;
  assign widx        = IW'(in_item_i.coef_index);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign nt    = (32'(tdeg_q) > MAX_DEGREE) ? DEG_MAX : IW'(tdeg_q);
  assign ns    = (32'(sdeg_q) > MAX_DEGREE) ? DEG_MAX : IW'(sdeg_q);
  assign n_cur = (pass_q == PASS_T) ? nt : ns;
  assign p_en  = (pass_q != PASS_T) || !kind_q;
  assign d_en  = (pass_q != PASS_T) || kind_q;

  always_comb begin
    unique case (pass_q)
      PASS_T:  s_cur = time_value_q;
      PASS_X:  s_cur = x_q;
      PASS_Y:  s_cur = y_q;
      default: s_cur = z_q;
    endcase
  end

  assign coef_rd = (pass_q == PASS_T) ? (trv_q ? trd_q : '0) : (srv_q ? srd_q : '0);

  always_comb begin
    unique case (st_q)
      ST_IDLE:   raddr = nt;
      ST_LD:     raddr = (n_cur == '0) ? ns : n_cur - 1'b1;
      ST_STEP_B: raddr = (i_q == '0) ? ns : i_q - 1'b1;
      default:   raddr = ns;
    endcase
  end

  assign pzs = dim2_q ? FX_ONE : pz_q;

  always_comb begin
    unique case (op_q)
      OP_T_DX:     begin opa = t_q;   opb = dx_q; end
      OP_ACC_PY:   begin opa = acc_q; opb = py_q; end
      OP_ACC_PZ_A: begin opa = acc_q; opb = pzs;  end
      OP_T_PX:     begin opa = t_q;   opb = px_q; end
      OP_ACC_DY:   begin opa = acc_q; opb = dy_q; end
      OP_ACC_PZ_B: begin opa = acc_q; opb = pzs;  end
      OP_TP_PY:    begin opa = tp_q;  opb = py_q; end
      default:     begin opa = acc_q; opb = dz_q; end
    endcase
  end

  assign mul_a = (st_q == ST_STEP_A) ? r_p_q : (st_q == ST_STEP_B) ? r_d_q : opa;
  assign mul_b = ((st_q == ST_STEP_A) || (st_q == ST_STEP_B)) ? s_cur : opb;
  assign mul_p = mul_a * mul_b;

  assign fl_x  = prod_q >>> FRAC_BITS;
  assign fl_s  = sat32(fl_x);
  assign add_b = (st_q == ST_STEP_B) ? coef_q : w_q;
  assign add_x = fl_s.v + add_b;
  assign add_s = sat32(add_x);

  assign w_n  = (st_q == ST_LD) ? n_cur : i_q;
  assign w_ns = {1'b0, w_n};
  assign w_x  = w_ns * coef_rd;
  assign w_s  = sat32(w_x);

  assign end_rp = (st_q == ST_LD) ? coef_rd : add_s.v;
  assign end_rd = (st_q == ST_LD) ? w_s.v : r_d_q;
  assign neg_x  = 64'sd0 - end_rd;
  assign neg_s  = sat32(neg_x);

  assign pass_end = ((st_q == ST_LD) && (n_cur == '0)) ||
                    ((st_q == ST_STEP_B) && (i_q == '0));
  assign last_op  = dim2_q ? (op_q == OP_ACC_PZ_B) : (op_q == OP_ACC_DZ_C);

  always_comb begin
    case (st_q)
      ST_LD:     ov_set = d_en && w_s.ov;
      ST_STEP_A: ov_set = (d_en && w_s.ov && (i_q != '0)) ||
                          (d_en && d_pend_q && (fl_s.ov || add_s.ov));
      ST_STEP_B: ov_set = p_en && (fl_s.ov || add_s.ov);
      ST_FIN:    ov_set = fl_s.ov;
      default:   ov_set = 1'b0;
    endcase
    if (pass_end && (pass_q == PASS_T) && kind_q) begin
      ov_set = ov_set || neg_s.ov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_value_q <= '0;
      tdeg_q       <= '0;
      sdeg_q       <= '0;
      kind_q       <= 1'b0;
      dim2_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIME_VALUE:   time_value_q <= cfg_data_i;
        CFG_TIME_DEGREE:  tdeg_q       <= cfg_data_i[2:0];
        CFG_SPACE_DEGREE: sdeg_q       <= cfg_data_i[2:0];
        CFG_FIELD_KIND:   kind_q       <= cfg_data_i[0];
        CFG_DIM_MODE:     dim2_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_spat) begin
      spat_mem[widx] <= in_item_i.coef_value;
    end
    if (load_time) begin
      time_mem[widx] <= in_item_i.coef_value;
    end
    srd_q <= spat_mem[raddr];
    trd_q <= time_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spat_vld_q <= '0;
      time_vld_q <= '0;
      srv_q      <= 1'b0;
      trv_q      <= 1'b0;
    end else begin
      if (load_spat) begin
        spat_vld_q[widx] <= 1'b1;
      end
      if (load_time) begin
        time_vld_q[widx] <= 1'b1;
      end
      srv_q <= spat_vld_q[raddr];
      trv_q <= time_vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pass_q      <= PASS_T;
      op_q        <= OP_T_DX;
      i_q         <= '0;
      d_pend_q    <= 1'b0;
      ov_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      r_p_q       <= '0;
      r_d_q       <= '0;
      coef_q      <= '0;
      w_q         <= '0;
      prod_q      <= '0;
      t_q         <= '0;
      px_q        <= '0;
      dx_q        <= '0;
      py_q        <= '0;
      dy_q        <= '0;
      pz_q        <= '0;
      dz_q        <= '0;
      acc_q       <= '0;
      tp_q        <= '0;
      res_a_q     <= '0;
      res_b_q     <= '0;
      res_c_q     <= '0;
    end else begin
      ov_q <= ov_q || ov_set;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (eval_acc) begin
            x_q     <= in_item_i.coord_x;
            y_q     <= in_item_i.coord_y;
            z_q     <= in_item_i.coord_z;
            pass_q  <= PASS_T;
            ov_q    <= 1'b0;
            res_c_q <= '0;
            st_q    <= ST_LD;
          end
        end
        ST_LD: begin
          r_p_q    <= coef_rd;
          r_d_q    <= w_s.v;
          d_pend_q <= 1'b0;
          i_q      <= n_cur - 1'b1;
          st_q     <= ST_STEP_A;
        end
        ST_STEP_A: begin
          coef_q   <= coef_rd;
          w_q      <= w_s.v;
          if (d_pend_q) begin
            r_d_q <= add_s.v;
          end
          d_pend_q <= 1'b0;
          prod_q   <= mul_p;
          st_q     <= ST_STEP_B;
        end
        ST_STEP_B: begin
          r_p_q  <= add_s.v;
          prod_q <= mul_p;
          if (i_q != '0) begin
            d_pend_q <= 1'b1;
            i_q      <= i_q - 1'b1;
            st_q     <= ST_STEP_A;
          end
        end
        ST_MUL: begin
          prod_q <= mul_p;
          st_q   <= ST_FIN;
        end
        ST_FIN: begin
          case (op_q) inside
            OP_T_DX, OP_ACC_PY, OP_ACC_DY, OP_TP_PY: acc_q <= fl_s.v;
            OP_T_PX: begin
              acc_q <= fl_s.v;
              tp_q  <= fl_s.v;
            end
            OP_ACC_PZ_A: res_a_q <= fl_s.v;
            OP_ACC_PZ_B: res_b_q <= fl_s.v;
            OP_ACC_DZ_C: res_c_q <= fl_s.v;
            default: ;
          endcase
          if (last_op) begin
            st_q <= ST_DONE;
          end else begin
            op_q <= op_e'(op_q + 3'd1);
            st_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_item_q  <= '{comp_a: res_a_q, comp_b: res_b_q, comp_c: res_c_q,
                             overflow: ov_q};
            out_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase

      if (pass_end) begin
        unique case (pass_q)
          PASS_T: begin
            t_q    <= kind_q ? neg_s.v : end_rp;
            pass_q <= PASS_X;
            st_q   <= ST_LD;
          end
          PASS_X: begin
            px_q   <= end_rp;
            dx_q   <= end_rd;
            pass_q <= PASS_Y;
            st_q   <= ST_LD;
          end
          PASS_Y: begin
            py_q <= end_rp;
            dy_q <= end_rd;
            if (dim2_q) begin
              op_q <= OP_T_DX;
              st_q <= ST_MUL;
            end else begin
              pass_q <= PASS_Z;
              st_q   <= ST_LD;
            end
          end
          default: begin
            pz_q <= end_rp;
            dz_q <= end_rd;
            op_q <= OP_T_DX;
            st_q <= ST_MUL;
          end
        endcase
      end
    end
  end

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_STEP_A) || (st_q == ST_STEP_B)) |-> (i_q < n_cur))
    else $error("Horner step index beyond degree");

  a_dpend_in_step_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_pend_q |-> (st_q == ST_STEP_A))
    else $error("derivative finish pending outside step A");

  a_no_z_in_2d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pass_q == PASS_Z) && ((st_q == ST_LD) || (st_q == ST_STEP_A) || (st_q == ST_STEP_B)))
    |-> !dim2_q)
    else $error("z pass run in 2D mode");

  a_ov_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc |=> !ov_q)
    else $error("overflow flag not cleared for new item");

  a_c_zero_2d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_DONE) && out_free && dim2_q) |=> (out_item_o.comp_c == '0))
    else $error("comp_c not zero in 2D mode");

endmodule

// ===== sim/separable_polynomial_field_evaluator_tb.sv =====
`timescale 1ns / 100ps

module separable_polynomial_field_evaluator_tb;
  import spfe_pkg::*;

  localparam longint     SAT_HI          = 64'sd2147483647;
  localparam longint     SAT_LO          = -64'sd2147483648;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam bit         KIND_SOLUTION   = 1'b0;
  localparam bit         KIND_RHS        = 1'b1;
  localparam bit         DIM_3D          = 1'b0;
  localparam bit         DIM_2D          = 1'b1;
  localparam int         HOLD_CYCLES     = 800;
  localparam int         DRAIN_CYCLES    = 100;
  localparam int         PHASES          = 12;
  localparam int         ITEMS_PER_PHASE = 134;

  class field_scoreboard;
    int          space_tab[8];
    int          time_tab[8];
    int          time_val;
    int unsigned time_deg;
    int unsigned space_deg;
    bit          rhs;
    bit          two_d;
    bit          sat_hit;
    int          errors;
    out_item_t   expected_fields[$];

    function int clip(longint v);
      if (v > SAT_HI) begin
        sat_hit = 1'b1;
        return int'(SAT_HI);
      end
      if (v < SAT_LO) begin
        sat_hit = 1'b1;
        return int'(SAT_LO);
      end
      return int'(v);
    endfunction

    function int fx_mul(int a, int b);
      return clip((longint'(a) * longint'(b)) >>> FRAC_BITS_DEF);
    endfunction

    function int horner_val(int c[8], int unsigned n, int s);
      int r;
      r = c[n];
      for (int i = int'(n) - 1; i >= 0; i--)
        r = clip(longint'(fx_mul(r, s)) + longint'(c[i]));
      return r;
    endfunction

    function int horner_slope(int c[8], int unsigned n, int s);
      int r;
      int w;
      r = clip(longint'(n) * longint'(c[n]));
      for (int i = int'(n) - 1; i >= 1; i--) begin
        w = clip(longint'(i) * longint'(c[i]));
        r = clip(longint'(fx_mul(r, s)) + longint'(w));
      end
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_TIME_VALUE:   time_val = data;
        CFG_TIME_DEGREE:  time_deg = data[2:0];
        CFG_SPACE_DEGREE: space_deg = data[2:0];
        CFG_FIELD_KIND:   rhs = data[0];
        CFG_DIM_MODE:     two_d = data[0];
        default: ;
      endcase
    endfunction

    function out_item_t field_products(in_item_t it);
      out_item_t res;
      int t, px, py, pz, dx, dy, dz, a, b, c;
      sat_hit = 1'b0;
      c = 0;
      if (rhs == KIND_SOLUTION) begin
        t = horner_val(time_tab, time_deg, time_val);
      end else begin
        t = horner_slope(time_tab, time_deg, time_val);
        t = clip(-longint'(t));
      end
      px = horner_val(space_tab, space_deg, it.coord_x);
      dx = horner_slope(space_tab, space_deg, it.coord_x);
      py = horner_val(space_tab, space_deg, it.coord_y);
      dy = horner_slope(space_tab, space_deg, it.coord_y);
      a = fx_mul(fx_mul(t, dx), py);
      b = fx_mul(fx_mul(t, px), dy);
      if (two_d == DIM_3D) begin
        pz = horner_val(space_tab, space_deg, it.coord_z);
        dz = horner_slope(space_tab, space_deg, it.coord_z);
        a = fx_mul(a, pz);
        b = fx_mul(b, pz);
        c = fx_mul(fx_mul(fx_mul(t, px), py), dz);
      end
      res.comp_a = a;
      res.comp_b = b;
      res.comp_c = c;
      res.overflow = sat_hit;
      return res;
    endfunction

    function void note_item(in_item_t it);
      case (it.cmd)
        CMD_LOAD_SPACE: space_tab[it.coef_index] = it.coef_value;
        CMD_LOAD_TIME:  time_tab[it.coef_index] = it.coef_value;
        CMD_EVAL:       expected_fields.push_back(field_products(it));
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_fields.size() == 0) begin
        errors++;
        $display("%0t: unexpected result a=%h b=%h c=%h ov=%b", $time,
                 got.comp_a, got.comp_b, got.comp_c, got.overflow);
        return;
      end
      want = expected_fields.pop_front();
      if (got.comp_a !== want.comp_a) begin
        errors++;
        $display("%0t: comp_a expected %h, got %h", $time, want.comp_a, got.comp_a);
      end
      if (got.comp_b !== want.comp_b) begin
        errors++;
        $display("%0t: comp_b expected %h, got %h", $time, want.comp_b, got.comp_b);
      end
      if (got.comp_c !== want.comp_c) begin
        errors++;
        $display("%0t: comp_c expected %h, got %h", $time, want.comp_c, got.comp_c);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %b, got %b", $time, want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  field_scoreboard sb = new();
  int send_idle_pct = 23;
  int recv_idle_pct = 81;
  bit hold_armed = 1'b0;
  bit held_once = 1'b0;
  int hold_left = 0;

  separable_polynomial_field_evaluator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !held_once && out_valid) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_item);
  end

  function automatic int rand_fx();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return 32'sh00010000;
          4: return -1;
          default: return 32'shffff0000;
        endcase
      end
      2, 3, 4, 5, 6: return int'($urandom_range(0, 262143)) - 131072;
      default: return int'($urandom_range(0, 131071)) - 65536;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, int idx, int val,
                                         int x, int y, int z);
    in_item_t it;
    it.cmd = cmd;
    it.coef_index = idx[2:0];
    it.coef_value = val;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input int tv, input int unsigned td, input int unsigned sd,
                              input bit kind, input bit dim);
    write_reg(CFG_TIME_VALUE, tv);
    write_reg(CFG_TIME_DEGREE, td);
    write_reg(CFG_SPACE_DEGREE, sd);
    write_reg(CFG_FIELD_KIND, kind);
    write_reg(CFG_DIM_MODE, dim);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_fields.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int counted;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(CMD_EVAL, 0, 0, 32'sh00010000, 32'sh00020000, -32'sh00010000));
    drain();

    apply_config(32'sh00018000, 2, 3, KIND_SOLUTION, DIM_3D);
    send_item(make_item(CMD_LOAD_TIME, 0, 32'sh00010000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_TIME, 1, 32'shffff8000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_TIME, 2, 32'sh00004000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_SPACE, 0, 32'sh7fffffff, 0, 0, 0));
    send_item(make_item(CMD_LOAD_SPACE, 1, 32'sh80000000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_SPACE, 2, 32'sh00010000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_SPACE, 3, -1, 0, 0, 0));
    send_item(make_item(CMD_UNUSED, 7, -1, -1, -1, -1));
    send_item(make_item(CMD_EVAL, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_EVAL, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000));
    send_item(make_item(CMD_EVAL, 0, 0, 32'sh80000000, 32'sh7fffffff, -1));
    send_item(make_item(CMD_LOAD_SPACE, 0, 32'sh00008000, 0, 0, 0));
    send_item(make_item(CMD_LOAD_SPACE, 1, -32'sh00020000, 0, 0, 0));
    send_item(make_item(CMD_EVAL, 0, 0, 32'sh00008000, -32'sh0000c000, 32'sh00014000));
    drain();

    apply_config(32'sh80000000, 7, 0, KIND_RHS, DIM_2D);
    send_item(make_item(CMD_EVAL, 0, 0, 32'sh00010000, 32'sh00010000, 32'sh7fffffff));
    send_item(make_item(CMD_LOAD_TIME, 7, 32'sh7fffffff, 0, 0, 0));
    send_item(make_item(CMD_EVAL, 0, 0, rand_fx(), rand_fx(), rand_fx()));
    drain();

    apply_config(32'sh7fffffff, 0, 7, KIND_RHS, DIM_3D);
    send_item(make_item(CMD_EVAL, 0, 0, rand_fx(), rand_fx(), rand_fx()));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 81;
      end else if (ph < 8) begin
        send_idle_pct = 81;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: apply_config(32'sh7fffffff, 7, 7, KIND_RHS, DIM_3D);
        1: apply_config(32'sh80000000, 0, 0, KIND_SOLUTION, DIM_2D);
        default: apply_config(rand_fx(), $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      if (ph == 0)
        hold_armed = 1'b1;
      for (int i = 0; i < 8; i++) begin
        send_item(make_item(CMD_LOAD_SPACE, i, rand_fx(), $urandom, $urandom, $urandom));
        send_item(make_item(CMD_LOAD_TIME, i, rand_fx(), $urandom, $urandom, $urandom));
      end
      counted = 16;
      while (counted < ITEMS_PER_PHASE) begin
        it = make_item(CMD_EVAL, $urandom_range(0, 7), rand_fx(), rand_fx(), rand_fx(),
                       rand_fx());
        r = $urandom_range(0, 99);
        if (r < 4)
          it.cmd = CMD_UNUSED;
        else if (r < 64)
          it.cmd = CMD_EVAL;
        else if (r < 82)
          it.cmd = CMD_LOAD_SPACE;
        else
          it.cmd = CMD_LOAD_TIME;
        if (it.cmd != CMD_UNUSED)
          counted++;
        send_item(it);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/spfe_pkg.sv
hdl/separable_polynomial_field_evaluator.sv
sim/separable_polynomial_field_evaluator_tb.sv
